// File: hw/rtl/linear_probe_hash_table_top_macros.svh
// Assertion macros used by the hash table top module.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LPHT_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LPHT_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// File: hw/rtl/lpht_pkg.sv
package lpht_pkg;

  localparam int KEY_W      = 31;
  localparam int MOD_W      = 9;
  localparam int TABLE_SIZE = 256;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int IDX_W      = 8;
  localparam int DIV_CNT_W  = $clog2(KEY_W);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(7);

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [1:0] STAT_INSERTED  = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_FOUND     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROBE,
    ST_CMP
  } lpht_state_t;

endpackage

// File: hw/rtl/linear_probe_hash_table_top.sv
// Channel   Handshake        Payload
// input     start / busy     in_kind, in_key
// result    out_valid        out_status, out_slot_index
// config    cfg_we           cfg_wdata
//
// A transaction is taken when start is high and busy is low; busy then stays high.
// The home slot comes from a restoring divider, one key bit a cycle.
// An insert then probes slot after slot in the probe state; a search visits each
// occupied slot in two steps (key memory read, then compare) and stops at an empty slot.
// The result strobe follows the last probe cycle; the receiver cannot stall it.
// Reset (synchronous, rst_n low) empties the table at once and loads modulus 7.
`include "linear_probe_hash_table_top_macros.svh"

module linear_probe_hash_table_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [lpht_pkg::KEY_W-1:0] in_key,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [lpht_pkg::IDX_W-1:0] out_slot_index,
  input  logic                      cfg_we,
  input  logic [lpht_pkg::MOD_W-1:0] cfg_wdata
);

  import lpht_pkg::*;

  lpht_state_t state_r, state_nxt;
  logic                  kind_r, kind_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [KEY_W-1:0]      div_key_r, div_key_nxt;
  logic [MOD_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic [SLOT_W-1:0]     pos_r, pos_nxt;
  logic [SLOT_W-1:0]     probe_cnt_r, probe_cnt_nxt;
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [1:0]            out_status_r, out_status_nxt;
  logic [IDX_W-1:0]      out_slot_r, out_slot_nxt;
  logic [MOD_W-1:0]      hash_modulus_r;

  logic [MOD_W-1:0]  modulus;
  logic [MOD_W:0]    trial;
  logic [MOD_W:0]    trial_diff;
  logic [SLOT_W-1:0] pos_inc;
  logic              last_probe;
  logic              ram_we;
  logic [KEY_W-1:0]  ram_rdata;

  // A zero modulus behaves as one, so every key lands in slot zero.
  assign modulus    = (hash_modulus_r == '0) ? MOD_W'(1) : hash_modulus_r;
  assign trial      = {rem_r, div_key_r[KEY_W-1]};
  assign trial_diff = trial - {1'b0, modulus};
  assign pos_inc    = (pos_r == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos_r + SLOT_W'(1);
  assign last_probe = (probe_cnt_r == SLOT_W'(TABLE_SIZE - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_modulus_r <= MOD_RESET;
    end else if (cfg_we) begin
      hash_modulus_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    div_key_r    <= div_key_nxt;
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    pos_r        <= pos_nxt;
    probe_cnt_r  <= probe_cnt_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    div_key_nxt    = div_key_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    pos_nxt        = pos_r;
    probe_cnt_nxt  = probe_cnt_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    ram_we         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt    = in_kind;
          key_nxt     = in_key;
          div_key_nxt = in_key;
          rem_nxt     = '0;
          div_cnt_nxt = '0;
          state_nxt   = ST_DIV;
        end
      end
      ST_DIV: begin
        // One restoring step: shift in the next key bit, subtract if it fits.
        rem_nxt     = trial_diff[MOD_W] ? trial[MOD_W-1:0] : trial_diff[MOD_W-1:0];
        div_key_nxt = {div_key_r[KEY_W-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(KEY_W - 1)) begin
          pos_nxt       = rem_nxt[SLOT_W-1:0];
          probe_cnt_nxt = '0;
          state_nxt     = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (!valid_r[pos_r]) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (kind_r == KIND_INSERT) begin
            ram_we           = 1'b1;
            valid_nxt[pos_r] = 1'b1;
            out_status_nxt   = STAT_INSERTED;
            out_slot_nxt     = IDX_W'(pos_r);
          end else begin
            out_status_nxt = STAT_NOT_FOUND;
            out_slot_nxt   = '0;
          end
        end else if (kind_r == KIND_SEARCH) begin
          state_nxt = ST_CMP;
        end else if (last_probe) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FULL;
          out_slot_nxt   = '0;
          state_nxt      = ST_IDLE;
        end else begin
          pos_nxt       = pos_inc;
          probe_cnt_nxt = probe_cnt_r + SLOT_W'(1);
        end
      end
      ST_CMP: begin
        if (ram_rdata == key_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_FOUND;
          out_slot_nxt   = IDX_W'(pos_r);
          state_nxt      = ST_IDLE;
        end else if (last_probe) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOT_FOUND;
          out_slot_nxt   = '0;
          state_nxt      = ST_IDLE;
        end else begin
          pos_nxt       = pos_inc;
          probe_cnt_nxt = probe_cnt_r + SLOT_W'(1);
          state_nxt     = ST_PROBE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  lpht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SIZE)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_r),
    .wdata (key_r),
    .raddr (pos_r),
    .rdata (ram_rdata)
  );

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

  `LPHT_ASSERT_NEXT(a_accept_divides, start && !busy, state_r == ST_DIV,
                    "accepted transaction did not enter the divider")
  `LPHT_ASSERT_NOW(a_result_from_probe, out_valid,
                   $past(state_r) == ST_PROBE || $past(state_r) == ST_CMP,
                   "result strobe not preceded by a probe cycle")
  `LPHT_ASSERT_NEXT(a_match_reports_found, state_r == ST_CMP && ram_rdata == key_r,
                    out_valid && out_status == STAT_FOUND,
                    "key match did not report found")
  `LPHT_ASSERT_NOW(a_insert_sets_valid, out_valid && out_status == STAT_INSERTED,
                   valid_r[out_slot_index[SLOT_W-1:0]],
                   "inserted slot not marked occupied")

endmodule

// File: hw/rtl/lpht_ram.sv
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: bench/linear_probe_hash_table_top_tb.sv
`timescale 1ns / 1ps

module linear_probe_hash_table_top_tb;
  import lpht_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] slot;
  } probe_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_kind;
  logic [KEY_W-1:0] in_key;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_slot_index;
  logic             cfg_we;
  logic [MOD_W-1:0] cfg_wdata;

  // Shadow copy of the table and its modulus register.
  logic [KEY_W-1:0] slot_key [TABLE_SIZE];
  bit               slot_used [TABLE_SIZE];
  logic [MOD_W-1:0] modulus;
  int unsigned      occupied;

  probe_result_t    pending_results [$];
  logic [KEY_W-1:0] stored_keys [$];
  int unsigned      mismatch_count;
  bit               idle_bursts;

  linear_probe_hash_table_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_slot_index(out_slot_index),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Walks the probe sequence on the shadow table and updates it for an insert.
  function automatic probe_result_t probe_table(input logic kind, input logic [KEY_W-1:0] key);
    probe_result_t res;
    int unsigned   div;
    int unsigned   home;
    int unsigned   s;
    int            i;
    div = modulus;
    if (div == 0) div = 1;
    home = (int'(key) % div) % TABLE_SIZE;
    res.status = (kind == KIND_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
    res.slot = '0;
    for (i = 0; i < TABLE_SIZE; i++) begin
      s = (home + i) % TABLE_SIZE;
      if (kind == KIND_INSERT) begin
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          slot_key[s] = key;
          occupied++;
          res.status = STAT_INSERTED;
          res.slot = IDX_W'(s);
          break;
        end
      end else begin
        if (!slot_used[s]) break;
        if (slot_key[s] == key) begin
          res.status = STAT_FOUND;
          res.slot = IDX_W'(s);
          break;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return KEY_W'($urandom);
    if (sel < 6 || stored_keys.size() == 0) return KEY_W'($urandom_range(0, 1023));
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  task automatic send_item(input logic kind, input logic [KEY_W-1:0] key);
    probe_result_t res;
    if (idle_bursts && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      // Half the bursts start only once the block has gone idle.
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start   <= 1'b1;
    in_kind <= kind;
    in_key  <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = probe_table(kind, key);
    if (res.status == STAT_INSERTED) stored_keys.push_back(key);
    pending_results.push_back(res);
  endtask

  // The modulus may only change while no transaction is in flight.
  task automatic write_modulus(input logic [MOD_W-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we  <= 1'b0;
    modulus = value;
  endtask

  task automatic test_reset_modulus();
    send_item(KIND_SEARCH, '0);
    send_item(KIND_INSERT, KEY_W'(0));
    send_item(KIND_INSERT, KEY_W'(7));
    send_item(KIND_INSERT, KEY_W'(14));
    send_item(KIND_SEARCH, KEY_W'(7));
    send_item(KIND_SEARCH, KEY_W'(21));
    send_item(KIND_INSERT, '1);
    send_item(KIND_SEARCH, '1);
    send_item(KIND_INSERT, KEY_W'(7));
    send_item(KIND_SEARCH, KEY_W'(7));
  endtask

  task automatic test_zero_modulus();
    write_modulus('0);
    send_item(KIND_INSERT, KEY_W'(5));
    send_item(KIND_SEARCH, KEY_W'(5));
  endtask

  // Moduli at and above the table size, with probes that wrap to slot 0.
  task automatic test_wide_modulus();
    write_modulus('1);
    send_item(KIND_INSERT, KEY_W'(510));
    send_item(KIND_INSERT, KEY_W'(510));
    send_item(KIND_INSERT, KEY_W'(510));
    send_item(KIND_SEARCH, KEY_W'(510));
    write_modulus(MOD_W'(TABLE_SIZE));
    send_item(KIND_INSERT, KEY_W'(255));
    send_item(KIND_SEARCH, KEY_W'(767));
  endtask

  task automatic test_unit_modulus();
    write_modulus(MOD_W'(1));
    send_item(KIND_INSERT, '1);
    send_item(KIND_SEARCH, KEY_W'(12345));
  endtask

  task automatic test_random_traffic();
    int phase;
    int n;
    logic [MOD_W-1:0] m;
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: m = MOD_W'($urandom_range(2, 300));
        1: m = MOD_W'(TABLE_SIZE);
        2: m = MOD_W'(TABLE_SIZE - 1);
        3: m = MOD_W'(1);
        4: m = '1;
        5: m = '0;
        6: m = MOD_W'($urandom_range(1, 511));
        default: m = MOD_W'(13);
      endcase
      write_modulus(m);
      idle_bursts = (phase % 2 == 0);
      for (n = 0; n < 130; n++) begin
        if ($urandom_range(0, 99) < 18) send_item(KIND_INSERT, pick_key());
        else send_item(KIND_SEARCH, pick_key());
      end
    end
  endtask

  // Fills every slot, then exercises inserts and searches on a full table.
  task automatic test_full_table();
    int n;
    idle_bursts = 1'b0;
    write_modulus(MOD_W'($urandom_range(1, 511)));
    while (occupied < TABLE_SIZE) send_item(KIND_INSERT, KEY_W'($urandom));
    for (n = 0; n < 4; n++) begin
      send_item(KIND_INSERT, KEY_W'($urandom));
      send_item(KIND_SEARCH, KEY_W'($urandom));
      send_item(KIND_SEARCH, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
    end
  endtask

  always @(posedge clk) begin
    probe_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d slot %0d", out_status, out_slot_index);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_slot_index !== want.slot) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                     want.status, want.slot, out_status, out_slot_index);
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("** linear_probe_hash_table_top: FAILED **");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_kind   <= 1'b0;
    in_key    <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    modulus = MOD_RESET;
    occupied = 0;
    mismatch_count = 0;
    idle_bursts = 1'b1;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_modulus();
    test_zero_modulus();
    test_wide_modulus();
    test_unit_modulus();
    test_random_traffic();
    test_full_table();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** linear_probe_hash_table_top: PASSED **");
    end else begin
      $display("** linear_probe_hash_table_top: FAILED **");
    end
    $finish;
  end

endmodule
